// ----- sv/irhi_pkg.sv -----
package irhi_pkg;

  localparam int unsigned MAX_SLOTS_DEF      = 4096;
  localparam int unsigned MIN_SLOTS_DEF      = 256;
  localparam int unsigned MIGRATE_PER_OP_DEF = 5;
  localparam int unsigned CLUSTER_LEN_DEF    = 9;

  localparam logic [31:0] HASH_MULT = 32'h53B2_3891;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_ZERO_KEY  = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PR_MIG,
    PR_INS,
    PR_FIND_NEW,
    PR_FIND_OLD
  } purpose_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MIG_RD,
    S_MIG_CHK,
    S_MIG_END,
    S_GROW_CHK,
    S_GROW_CLR,
    S_INS_DEC,
    S_SETUP,
    S_DISP,
    S_PRB_RD,
    S_PRB_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] handle;
  } slot_t;

endpackage

// ----- sv/incremental_rehash_hash_index.sv -----
// a zero-key or full insert answers without probing; a find that misses in the new table
//   while growing falls back to the old one; a growth start clears the doubled table
// while growing, each request first visits up to MIGRATE_PER_OP old slots and moves each entry found
// throughput: one request at a time, in_stall_o is high until the request is done
// reset and every min_elements write: a clearing pass over all 2*MAX_SLOTS slots,
//   during which no request is taken
module incremental_rehash_hash_index #(
  parameter int unsigned MAX_SLOTS      = irhi_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MIN_SLOTS      = irhi_pkg::MIN_SLOTS_DEF,
  parameter int unsigned MIGRATE_PER_OP = irhi_pkg::MIGRATE_PER_OP_DEF,
  parameter int unsigned CLUSTER_LEN    = irhi_pkg::CLUSTER_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] node_key_i,
  input  logic [31:0] entry_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_handle_o
);

  // slot index width inside one bank, sizes need one more bit
  localparam int unsigned AW   = $clog2(MAX_SLOTS);
  localparam int unsigned SZW  = AW + 1;
  localparam int unsigned CNTW = AW + 2;
  localparam int unsigned IW   = $clog2(CLUSTER_LEN + 1);
  localparam int unsigned SW   = $clog2(MIGRATE_PER_OP + 1);
  localparam logic [AW-1:0]  HM      = AW'(irhi_pkg::HASH_MULT);
  localparam logic [SZW-1:0] HALF_SZ = SZW'(MAX_SLOTS / 2);

  irhi_pkg::state_e   state_q, state_d;
  irhi_pkg::purpose_e pur_q, pur_d;
  irhi_pkg::status_e  res_status_q, res_status_d;

  logic            req_q, req_d;
  logic [31:0]     key_q, key_d, hnd_q, hnd_d;
  logic [SW-1:0]   steps_q, steps_d;
  logic [SZW-1:0]  pos_q, pos_d;
  logic            ab_q, ab_d;
  logic [SZW-1:0]  asize_q, asize_d;
  logic            grow_q, grow_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            full_q, full_d;
  logic [AW:0]     clr_q, clr_d;
  logic [31:0]     pk_q, pk_d, ph_q, ph_d;
  logic            pbank_q, pbank_d;
  logic [SZW-1:0]  psize_q, psize_d;
  logic [AW-1:0]   h_q, h_d, disp_q, disp_d;
  logic [SZW-1:0]  c_q, c_d;
  logic [IW-1:0]   i_q, i_d;
  logic [31:0]     res_handle_q, res_handle_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [31:0]     out_handle_q, out_handle_d;

  // slot store, both banks, one write and one registered read per cycle
  irhi_pkg::slot_t mem [2*MAX_SLOTS];
  irhi_pkg::slot_t rd_q;
  irhi_pkg::slot_t mem_wd;
  logic            mem_we;
  logic [AW:0]     mem_wa, rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  // initial table size: smallest power of two with 3*p > 5*m, clamped
  logic [SZW-1:0] init_sz;
  logic [40:0]    m5;
  always_comb begin
    m5      = 41'(cfg_wdata_i) * 41'd5;
    init_sz = SZW'(MAX_SLOTS);
    for (int k = AW; k >= 0; k--) begin
      if ((41'd3 << k) > m5) begin
        init_sz = SZW'(1) << k;
      end
    end
    if (init_sz < SZW'(MIN_SLOTS)) begin
      init_sz = SZW'(MIN_SLOTS);
    end
  end

  logic [SZW-1:0]  asize2;
  logic [AW-1:0]   pmask, slot_idx;
  logic [AW-1:0]   prod;
  logic [CNTW+2:0] cnt5, size3;

  assign asize2   = asize_q << 1;
  assign pmask    = AW'(psize_q - SZW'(1));
  assign slot_idx = (h_q + AW'(i_q)) & pmask;
  // only the low index bits of the product matter
  assign prod     = h_q * HM;
  // load check: entries*5 > size*3
  assign cnt5     = (CNTW+3)'(cnt_q) * (CNTW+3)'(5);
  assign size3    = (CNTW+3)'(asize_q) * (CNTW+3)'(3);

  always_comb begin
    logic fin, good;
    fin          = 1'b0;
    good         = 1'b0;
    state_d      = state_q;
    pur_d        = pur_q;
    res_status_d = res_status_q;
    req_d        = req_q;
    key_d        = key_q;
    hnd_d        = hnd_q;
    steps_d      = steps_q;
    pos_d        = pos_q;
    ab_d         = ab_q;
    asize_d      = asize_q;
    grow_d       = grow_q;
    cnt_d        = cnt_q;
    full_d       = full_q;
    clr_d        = clr_q;
    pk_d         = pk_q;
    ph_d         = ph_q;
    pbank_d      = pbank_q;
    psize_d      = psize_q;
    h_d          = h_q;
    disp_d       = disp_q;
    c_d          = c_q;
    i_d          = i_q;
    res_handle_d = res_handle_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    rd_addr      = '0;

    case (state_q)
      irhi_pkg::S_CLEAR: begin
        // sweep both banks, marking every slot free
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = irhi_pkg::S_IDLE;
        end
      end
      irhi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          key_d   = node_key_i;
          hnd_d   = entry_handle_i;
          steps_d = SW'(MIGRATE_PER_OP);
          state_d = grow_q ? irhi_pkg::S_MIG_RD : irhi_pkg::S_GROW_CHK;
        end
      end
      irhi_pkg::S_MIG_RD: begin
        if (steps_q != '0 && pos_q < asize_q) begin
          rd_addr = {ab_q, pos_q[AW-1:0]};
          state_d = irhi_pkg::S_MIG_CHK;
        end else begin
          state_d = irhi_pkg::S_MIG_END;
        end
      end
      irhi_pkg::S_MIG_CHK: begin
        pos_d   = pos_q + 1'b1;
        steps_d = steps_q - 1'b1;
        if (rd_q.used && rd_q.key != '0) begin
          pk_d    = rd_q.key;
          ph_d    = rd_q.handle;
          pbank_d = ~ab_q;
          psize_d = asize2;
          pur_d   = irhi_pkg::PR_MIG;
          state_d = irhi_pkg::S_SETUP;
        end else begin
          state_d = irhi_pkg::S_MIG_RD;
        end
      end
      irhi_pkg::S_MIG_END: begin
        if (pos_q >= asize_q) begin
          ab_d    = ~ab_q;
          asize_d = asize2;
          grow_d  = 1'b0;
          pos_d   = '0;
        end
        state_d = irhi_pkg::S_GROW_CHK;
      end
      irhi_pkg::S_GROW_CHK: begin
        full_d = 1'b0;
        pk_d   = key_q;
        ph_d   = hnd_q;
        if (req_q == irhi_pkg::REQ_FIND) begin
          if (grow_q) begin
            pbank_d = ~ab_q;
            psize_d = asize2;
            pur_d   = irhi_pkg::PR_FIND_NEW;
          end else begin
            pbank_d = ab_q;
            psize_d = asize_q;
            pur_d   = irhi_pkg::PR_FIND_OLD;
          end
          state_d = irhi_pkg::S_SETUP;
        end else if (!grow_q && cnt5 > size3) begin
          if (asize_q <= HALF_SZ) begin
            grow_d  = 1'b1;
            pos_d   = '0;
            clr_d   = '0;
            state_d = irhi_pkg::S_GROW_CLR;
          end else begin
            full_d  = 1'b1;
            state_d = irhi_pkg::S_INS_DEC;
          end
        end else begin
          state_d = irhi_pkg::S_INS_DEC;
        end
      end
      irhi_pkg::S_GROW_CLR: begin
        // free the slots of the doubled table in the other bank
        mem_we = 1'b1;
        mem_wa = {~ab_q, clr_q[AW-1:0]};
        clr_d  = clr_q + 1'b1;
        if (clr_q == asize2 - SZW'(1)) begin
          state_d = irhi_pkg::S_INS_DEC;
        end
      end
      irhi_pkg::S_INS_DEC: begin
        res_handle_d = '0;
        if (key_q == '0) begin
          res_status_d = irhi_pkg::STAT_ZERO_KEY;
          state_d      = irhi_pkg::S_RESP;
        end else if (full_q) begin
          res_status_d = irhi_pkg::STAT_FULL;
          state_d      = irhi_pkg::S_RESP;
        end else begin
          pbank_d = grow_q ? ~ab_q : ab_q;
          psize_d = grow_q ? asize2 : asize_q;
          pur_d   = irhi_pkg::PR_INS;
          state_d = irhi_pkg::S_SETUP;
        end
      end
      irhi_pkg::S_SETUP: begin
        // key*33, only the low index bits matter
        h_d     = pk_q[AW-1:0] + {pk_q[AW-6:0], 5'b0};
        state_d = irhi_pkg::S_DISP;
      end
      irhi_pkg::S_DISP: begin
        disp_d  = (prod & pmask) | AW'(1);
        c_d     = '0;
        i_d     = '0;
        state_d = irhi_pkg::S_PRB_RD;
      end
      irhi_pkg::S_PRB_RD: begin
        rd_addr = {pbank_q, slot_idx};
        state_d = irhi_pkg::S_PRB_CHK;
      end
      irhi_pkg::S_PRB_CHK: begin
        if (pur_q == irhi_pkg::PR_MIG || pur_q == irhi_pkg::PR_INS) begin
          if (!rd_q.used) begin
            mem_we        = 1'b1;
            mem_wa        = {pbank_q, slot_idx};
            mem_wd.used   = 1'b1;
            mem_wd.key    = pk_q;
            mem_wd.handle = ph_q;
            fin           = 1'b1;
            good          = 1'b1;
          end
        end else begin
          if (!rd_q.used) begin
            fin = 1'b1;
          end else if (rd_q.key == pk_q) begin
            fin  = 1'b1;
            good = 1'b1;
          end
        end
        if (!fin) begin
          state_d = irhi_pkg::S_PRB_RD;
          if (i_q == IW'(CLUSTER_LEN - 1)) begin
            i_d = '0;
            h_d = h_q + disp_q;
            c_d = c_q + 1'b1;
            if (c_q == psize_q - SZW'(1)) begin
              fin = 1'b1;
            end
          end else begin
            i_d = i_q + 1'b1;
          end
        end
        if (fin) begin
          res_handle_d = '0;
          case (pur_q)
            irhi_pkg::PR_MIG: begin
              state_d = irhi_pkg::S_MIG_RD;
            end
            irhi_pkg::PR_INS: begin
              if (good) begin
                cnt_d        = cnt_q + 1'b1;
                res_status_d = irhi_pkg::STAT_OK;
              end else begin
                res_status_d = irhi_pkg::STAT_FULL;
              end
              state_d = irhi_pkg::S_RESP;
            end
            irhi_pkg::PR_FIND_NEW: begin
              if (good) begin
                res_status_d = irhi_pkg::STAT_OK;
                res_handle_d = rd_q.handle;
                state_d      = irhi_pkg::S_RESP;
              end else begin
                // miss in the new table, retry in the old one
                pbank_d = ab_q;
                psize_d = asize_q;
                pur_d   = irhi_pkg::PR_FIND_OLD;
                state_d = irhi_pkg::S_SETUP;
              end
            end
            default: begin
              if (good) begin
                res_status_d = irhi_pkg::STAT_OK;
                res_handle_d = rd_q.handle;
              end else begin
                res_status_d = irhi_pkg::STAT_NOT_FOUND;
              end
              state_d = irhi_pkg::S_RESP;
            end
          endcase
        end
      end
      irhi_pkg::S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          state_d      = irhi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = irhi_pkg::S_IDLE;
      end
    endcase

    // register write: resize and wipe the index
    if (cfg_we_i) begin
      state_d = irhi_pkg::S_CLEAR;
      clr_d   = '0;
      ab_d    = 1'b0;
      asize_d = init_sz;
      grow_d  = 1'b0;
      pos_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= irhi_pkg::S_CLEAR;
      pur_q        <= irhi_pkg::PR_MIG;
      res_status_q <= irhi_pkg::STAT_OK;
      req_q        <= 1'b0;
      key_q        <= '0;
      hnd_q        <= '0;
      steps_q      <= '0;
      pos_q        <= '0;
      ab_q         <= 1'b0;
      asize_q      <= SZW'(MIN_SLOTS);
      grow_q       <= 1'b0;
      cnt_q        <= '0;
      full_q       <= 1'b0;
      clr_q        <= '0;
      pk_q         <= '0;
      ph_q         <= '0;
      pbank_q      <= 1'b0;
      psize_q      <= '0;
      h_q          <= '0;
      disp_q       <= '0;
      c_q          <= '0;
      i_q          <= '0;
      res_handle_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_handle_q <= '0;
    end else begin
      state_q      <= state_d;
      pur_q        <= pur_d;
      res_status_q <= res_status_d;
      req_q        <= req_d;
      key_q        <= key_d;
      hnd_q        <= hnd_d;
      steps_q      <= steps_d;
      pos_q        <= pos_d;
      ab_q         <= ab_d;
      asize_q      <= asize_d;
      grow_q       <= grow_d;
      cnt_q        <= cnt_d;
      full_q       <= full_d;
      clr_q        <= clr_d;
      pk_q         <= pk_d;
      ph_q         <= ph_d;
      pbank_q      <= pbank_d;
      psize_q      <= psize_d;
      h_q          <= h_d;
      disp_q       <= disp_d;
      c_q          <= c_d;
      i_q          <= i_d;
      res_handle_q <= res_handle_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_handle_q <= out_handle_d;
    end
  end

  assign in_stall_o     = (state_q != irhi_pkg::S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_handle_o = out_handle_q;

`ifndef ASSERT_OFF
  a_grow_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grow_q |-> (asize_q <= HALF_SZ))
    else $error("growing while the doubled table would not fit");
  a_size_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(asize_q))
    else $error("active table size is not a power of two");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= asize_q)
    else $error("migration position ran past the old table");
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cfg_we_i) |=> in_stall_o)
    else $error("request beat did not start the sequencer");
`endif

endmodule
